// File: rtl/ir_pulse_to_serial_frame_top_macros.svh
// assertion macros for the ir pulse to serial frame block
// used by ir_pulse_to_serial_frame_top, expects clk and rst_n in scope
`ifndef IR_PULSE_TO_SERIAL_FRAME_TOP_MACROS_SVH
`define IR_PULSE_TO_SERIAL_FRAME_TOP_MACROS_SVH

// same-cycle implication
`define IRPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irpf assertion failed");

// next-cycle implication
`define IRPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irpf assertion failed");

`endif

// File: rtl/irpf_pkg.sv
// shared constants for the ir pulse to serial frame block
// no dependencies
package irpf_pkg;

    localparam int DEFAULT_MAX_DATA_BYTES = 27;

    localparam int SPACE_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_SEL_W = 3;

    localparam logic [BYTE_W-1:0] WAKE_LEAD = 8'hFA;
    localparam logic [BYTE_W-1:0] WAKE_TAIL = 8'hF1;
    localparam logic [BYTE_W-1:0] FRAME_END = 8'hED;

    localparam int SKIP_FROM_COUNT = 3;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
    localparam logic [3:0] PAIRS_INVERTED = 4'd8;

    localparam logic [SPACE_W-1:0] RESET_BIT_ONE  = 16'd1000;
    localparam logic [SPACE_W-1:0] RESET_DATA_MAX = 16'd2000;
    localparam logic [SPACE_W-1:0] RESET_START    = 16'd4000;
    localparam logic [SPACE_W-1:0] RESET_END      = 16'd5000;

    localparam logic [REG_SEL_W-1:0] REG_CARRIER   = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_BIT_ONE   = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_DATA_MAX  = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_START_MIN = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_END_MIN   = 3'd4;

    localparam logic FRAME_KIND_WAKE = 1'b0;
    localparam logic FRAME_KIND_DATA = 1'b1;

endpackage

// File: rtl/irpf_pulse_if.sv
// valid/ready channel carrying one ir mark/space pair
// depends on irpf_pkg
interface irpf_pulse_if;
    import irpf_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPACE_W-1:0] space_time;
    logic               first_pair;
    logic               last_pair;

    modport source (output valid, output space_time, output first_pair,
                    output last_pair, input ready);
    modport sink (input valid, input space_time, input first_pair,
                  input last_pair, output ready);
endinterface

// File: rtl/irpf_frame_if.sv
// valid/ready channel carrying one serial output byte
// depends on irpf_pkg
interface irpf_frame_if;
    import irpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_kind;
    logic              last_of_frame;

    modport source (output valid, output out_byte, output frame_kind,
                    output last_of_frame, input ready);
    modport sink (input valid, input out_byte, input frame_kind,
                  input last_of_frame, output ready);
endinterface

// File: rtl/ir_pulse_to_serial_frame_top.sv
// Decodes ir mark/space pairs into serial frames, one pair per transaction. A pair is taken
// only while the block is idle; a first pair emits the two wake bytes before it is
// classified, and an end mark emits a frame of N data bytes, each stored byte being read
// from the frame memory into a read register before it is loaded into the output
// register. Output backpressure stalls the byte output. The frame memory needs no clearing
// after reset.
// depends on irpf_pkg, irpf_pulse_if, irpf_frame_if and the macros header
`include "ir_pulse_to_serial_frame_top_macros.svh"

module ir_pulse_to_serial_frame_top #(
    parameter int MAX_DATA_BYTES = irpf_pkg::DEFAULT_MAX_DATA_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    irpf_pulse_if.sink                     pulse,
    irpf_frame_if.source                   frame,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [irpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [irpf_pkg::PDATA_W-1:0]   pwdata,
    output logic [irpf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import irpf_pkg::*;

    localparam int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam int CW = $clog2(MAX_DATA_BYTES + 1);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_WAKE_LEAD = 11'b000_0000_0010,
        ST_WAKE_TAIL = 11'b000_0000_0100,
        ST_CLASSIFY  = 11'b000_0000_1000,
        ST_F_LEAD    = 11'b000_0001_0000,
        ST_F_COUNT   = 11'b000_0010_0000,
        ST_F_CARRIER = 11'b000_0100_0000,
        ST_F_FETCH   = 11'b000_1000_0000,
        ST_F_DATA    = 11'b001_0000_0000,
        ST_F_SUM     = 11'b010_0000_0000,
        ST_F_END     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [BYTE_W-1:0]  carrier_reg;
    logic [SPACE_W-1:0] bit_one_reg;
    logic [SPACE_W-1:0] data_max_reg;
    logic [SPACE_W-1:0] start_min_reg;
    logic [SPACE_W-1:0] end_min_reg;

    // decoder state
    logic [CW-1:0]      count_reg, count_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [3:0]         rem_reg, rem_next;
    logic [3:0]         skip_reg, skip_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [SPACE_W-1:0] space_reg, space_next;
    logic               last_reg, last_next;

    // output register
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_kind_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               out_load;
    logic [BYTE_W-1:0]  load_byte;
    logic               load_kind;
    logic               load_last;

    // frame memory
    logic [BYTE_W-1:0]  store_mem [MAX_DATA_BYTES];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;

    logic [BYTE_W-1:0]  bit_byte;
    logic [3:0]         bit_rem;
    logic [CW-1:0]      count_tmp;
    logic               finish;
    logic               cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg   <= '0;
            bit_one_reg   <= RESET_BIT_ONE;
            data_max_reg  <= RESET_DATA_MAX;
            start_min_reg <= RESET_START;
            end_min_reg   <= RESET_END;
        end
        else if (cfg_write)
        begin
            unique case (paddr[PADDR_W-1:2])
                REG_CARRIER:   carrier_reg   <= pwdata[BYTE_W-1:0];
                REG_BIT_ONE:   bit_one_reg   <= pwdata[SPACE_W-1:0];
                REG_DATA_MAX:  data_max_reg  <= pwdata[SPACE_W-1:0];
                REG_START_MIN: start_min_reg <= pwdata[SPACE_W-1:0];
                REG_END_MIN:   end_min_reg   <= pwdata[SPACE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_CARRIER:   prdata = PDATA_W'(carrier_reg);
            REG_BIT_ONE:   prdata = PDATA_W'(bit_one_reg);
            REG_DATA_MAX:  prdata = PDATA_W'(data_max_reg);
            REG_START_MIN: prdata = PDATA_W'(start_min_reg);
            REG_END_MIN:   prdata = PDATA_W'(end_min_reg);
            default:       prdata = '0;
        endcase
    end

    // channels
    assign pulse.ready         = (state_reg == ST_IDLE);
    assign frame.valid         = out_valid_reg;
    assign frame.out_byte      = out_byte_reg;
    assign frame.frame_kind    = out_kind_reg;
    assign frame.last_of_frame = out_last_reg;
    assign out_free            = !out_valid_reg || frame.ready;

    // next bit of the byte being assembled
    always_comb
    begin
        bit_byte = {(space_reg > bit_one_reg),
                    (rem_reg != 4'd0) ? shift_reg[BYTE_W-1:1] : 7'd0};
        bit_rem  = ((rem_reg != 4'd0) ? rem_reg : BITS_PER_BYTE) - 4'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        skip_next  = skip_reg;
        idx_next   = idx_reg;
        space_next = space_reg;
        last_next  = last_reg;
        out_load   = 1'b0;
        load_byte  = WAKE_LEAD;
        load_kind  = FRAME_KIND_WAKE;
        load_last  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = bit_byte;
        count_tmp  = count_reg;
        finish     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pulse.valid)
                begin
                    space_next = pulse.space_time;
                    last_next  = pulse.last_pair;
                    if (pulse.first_pair)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        shift_next = '0;
                        rem_next   = '0;
                        skip_next  = '0;
                        state_next = ST_WAKE_LEAD;
                    end
                    else
                    begin
                        state_next = ST_CLASSIFY;
                    end
                end
            end
            ST_WAKE_LEAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = WAKE_LEAD;
                    load_kind  = FRAME_KIND_WAKE;
                    state_next = ST_WAKE_TAIL;
                end
            end
            ST_WAKE_TAIL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = WAKE_TAIL;
                    load_kind  = FRAME_KIND_WAKE;
                    load_last  = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                finish = 1'b1;
                if (skip_reg != 4'd0)
                begin
                    skip_next = skip_reg - 4'd1;
                end
                else if (rem_reg != 4'd0 || space_reg <= data_max_reg)
                begin
                    shift_next = bit_byte;
                    rem_next   = bit_rem;
                    if (bit_rem == 4'd0)
                    begin
                        if (count_reg < CW'(MAX_DATA_BYTES))
                        begin
                            mem_we    = 1'b1;
                            sum_next  = sum_reg + bit_byte;
                            count_tmp = count_reg + CW'(1);
                        end
                        count_next = count_tmp;
                        if (count_tmp >= CW'(SKIP_FROM_COUNT))
                        begin
                            skip_next = PAIRS_INVERTED;
                        end
                    end
                end
                else if (space_reg > start_min_reg && space_reg <= end_min_reg)
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
                else if (space_reg > end_min_reg && count_reg != '0)
                begin
                    finish     = 1'b0;
                    idx_next   = '0;
                    state_next = ST_F_LEAD;
                end
            end
            ST_F_LEAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = WAKE_LEAD;
                    load_kind  = FRAME_KIND_DATA;
                    state_next = ST_F_COUNT;
                end
            end
            ST_F_COUNT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = BYTE_W'(count_reg) + BYTE_W'(1);
                    load_kind  = FRAME_KIND_DATA;
                    state_next = ST_F_CARRIER;
                end
            end
            ST_F_CARRIER:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = carrier_reg;
                    load_kind  = FRAME_KIND_DATA;
                    state_next = ST_F_FETCH;
                end
            end
            ST_F_FETCH:
            begin
                state_next = ST_F_DATA;
            end
            ST_F_DATA:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_byte = rd_data_reg;
                    load_kind = FRAME_KIND_DATA;
                    if (CW'(idx_reg) + CW'(1) == count_reg)
                    begin
                        state_next = ST_F_SUM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_F_FETCH;
                    end
                end
            end
            ST_F_SUM:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = 8'h00 - sum_reg;
                    load_kind  = FRAME_KIND_DATA;
                    state_next = ST_F_END;
                end
            end
            ST_F_END:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_byte  = FRAME_END;
                    load_kind  = FRAME_KIND_DATA;
                    load_last  = 1'b1;
                    count_next = '0;
                    sum_next   = '0;
                    finish     = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = ST_IDLE;
            if (last_reg)
            begin
                count_next = '0;
                sum_next   = '0;
                shift_next = '0;
                rem_next   = '0;
                skip_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            shift_reg     <= '0;
            rem_reg       <= '0;
            skip_reg      <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            skip_reg  <= skip_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        space_reg <= space_next;
        if (out_load)
        begin
            out_byte_reg <= load_byte;
            out_kind_reg <= load_kind;
            out_last_reg <= load_last;
        end
    end

    // frame memory, at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    `IRPF_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= CW'(MAX_DATA_BYTES))
    `IRPF_ASSERT_NOW(a_skip_outside_byte, skip_reg != 4'd0, rem_reg == 4'd0)
    `IRPF_ASSERT_NOW(a_fetch_in_range, state_reg == ST_F_DATA, CW'(idx_reg) < count_reg)
    `IRPF_ASSERT_NOW(a_frame_ends_with_end, frame.valid && frame.last_of_frame && frame.frame_kind, frame.out_byte == FRAME_END)
    `IRPF_ASSERT_NEXT(a_first_wakes, pulse.valid && pulse.ready && pulse.first_pair, state_reg == ST_WAKE_LEAD)

endmodule
